@@ sv/phntl_pkg.sv @@
`default_nettype none

package phntl_pkg;

	localparam int unsigned TIME_W = 62;
	localparam int unsigned POSE_W = 32;

	localparam logic ACT_RECORD = 1'b0;
	localparam logic ACT_QUERY  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_GAP,
		ST_SEL,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

@@ sv/phntl_ram.sv @@
`default_nettype none

module phntl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ sv/pose_history_nearest_time_lookup_top.sv @@
// Record beat: the state goes to DONE and the result is offered once the output is free, then back to IDLE.
// Query beat: entries are read from the newest back, one per cycle (at most HISTORY_DEPTH), as set by
// the single read port of the history RAM; states GAP and SEL pick the nearer neighbour when the
// stop lies below the newest, then DONE offers the result.
// One beat is worked on at a time; a new beat is taken while a result waits at the output.
// Reset clears the slot pointer and fill count and sets the pose counter to one; the RAM is not cleared.
`default_nettype none

module pose_history_nearest_time_lookup_top #(
	parameter int unsigned HISTORY_DEPTH = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           action,
	input  wire logic [phntl_pkg::TIME_W-1:0]   time_ns,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [phntl_pkg::POSE_W-1:0]   pose_number,
	output logic                                empty_error
);

	localparam int unsigned AW = $clog2(HISTORY_DEPTH);
	localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned DW = phntl_pkg::TIME_W + phntl_pkg::POSE_W;

	phntl_pkg::state_t state_q, state_d;

	logic [AW-1:0]                  write_slot_q;
	logic [FW-1:0]                  fill_count_q;
	logic [phntl_pkg::POSE_W-1:0]   pose_counter_q;
	logic                           out_valid_q;
	logic [phntl_pkg::POSE_W-1:0]   pose_number_q;
	logic                           empty_error_q;

	logic [phntl_pkg::TIME_W-1:0]   time_q;
	logic [AW-1:0]                  rd_ptr_q;
	logic [AW-1:0]                  ev_k_q;
	logic [phntl_pkg::TIME_W-1:0]   prev_time_q;
	logic [phntl_pkg::POSE_W-1:0]   prev_pose_q;
	logic [phntl_pkg::TIME_W-1:0]   old_time_q;
	logic [phntl_pkg::POSE_W-1:0]   old_pose_q;
	logic [phntl_pkg::TIME_W-1:0]   gap_old_q;
	logic [phntl_pkg::TIME_W-1:0]   gap_new_q;
	logic [phntl_pkg::POSE_W-1:0]   res_pose_q;
	logic                           res_err_q;

	logic                           in_acc;
	logic                           out_free;
	logic [AW-1:0]                  newest_slot;
	logic [AW-1:0]                  after_newest;
	logic [AW-1:0]                  rd_ptr_dec;
	logic [phntl_pkg::POSE_W-1:0]   pose_next;
	logic                           hit;
	logic                           last;

	logic                           ram_we;
	logic [AW-1:0]                  ram_raddr;
	logic [DW-1:0]                  ram_wdata;
	logic [DW-1:0]                  ram_rdata;
	logic [phntl_pkg::TIME_W-1:0]   rd_time;
	logic [phntl_pkg::POSE_W-1:0]   rd_pose;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign newest_slot  = (write_slot_q == '0) ? AW'(HISTORY_DEPTH - 1)
	                                           : write_slot_q - AW'(1);
	assign after_newest = (newest_slot == '0) ? AW'(HISTORY_DEPTH - 1)
	                                          : newest_slot - AW'(1);
	assign rd_ptr_dec   = (rd_ptr_q == '0) ? AW'(HISTORY_DEPTH - 1) : rd_ptr_q - AW'(1);
	assign pose_next    = pose_counter_q + phntl_pkg::POSE_W'(1);

	assign rd_time = ram_rdata[DW-1:phntl_pkg::POSE_W];
	assign rd_pose = ram_rdata[phntl_pkg::POSE_W-1:0];
	assign hit     = (rd_time <= time_q);
	assign last    = (FW'(ev_k_q) == fill_count_q - FW'(1));

	assign ram_wdata = {time_ns, pose_next};

	phntl_ram #(
		.WIDTH(DW),
		.DEPTH(HISTORY_DEPTH)
	) u_hist_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(write_slot_q),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			phntl_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (action == phntl_pkg::ACT_RECORD || fill_count_q == '0) begin
						state_d = phntl_pkg::ST_DONE;
					end else begin
						state_d = phntl_pkg::ST_WALK;
					end
				end
			end
			phntl_pkg::ST_WALK: begin
				if (hit) begin
					state_d = (ev_k_q == '0) ? phntl_pkg::ST_DONE : phntl_pkg::ST_GAP;
				end else if (last) begin
					state_d = phntl_pkg::ST_DONE;
				end
			end
			phntl_pkg::ST_GAP:  state_d = phntl_pkg::ST_SEL;
			phntl_pkg::ST_SEL:  state_d = phntl_pkg::ST_DONE;
			phntl_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = phntl_pkg::ST_IDLE;
				end
			end
			default: state_d = phntl_pkg::ST_IDLE;
		endcase
	end

	// The read port walks one entry back per cycle; data for entry k arrives while k is judged.
	always_comb begin
		in_stall  = 1'b1;
		ram_we    = 1'b0;
		ram_raddr = rd_ptr_q;
		case (state_q)
			phntl_pkg::ST_IDLE: begin
				in_stall  = 1'b0;
				ram_we    = in_valid && (action == phntl_pkg::ACT_RECORD);
				ram_raddr = newest_slot;
			end
			default: begin
				in_stall  = 1'b1;
				ram_we    = 1'b0;
				ram_raddr = rd_ptr_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= phntl_pkg::ST_IDLE;
			write_slot_q   <= '0;
			fill_count_q   <= '0;
			pose_counter_q <= phntl_pkg::POSE_W'(1);
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				pose_counter_q <= pose_next;
				write_slot_q   <= (write_slot_q == AW'(HISTORY_DEPTH - 1)) ? '0
				                                                         : write_slot_q + AW'(1);
				if (fill_count_q != FW'(HISTORY_DEPTH)) begin
					fill_count_q <= fill_count_q + FW'(1);
				end
			end
			if (state_q == phntl_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			phntl_pkg::ST_IDLE: begin
				if (in_acc) begin
					time_q   <= time_ns;
					rd_ptr_q <= after_newest;
					ev_k_q   <= '0;
					if (action == phntl_pkg::ACT_RECORD) begin
						res_pose_q <= pose_next;
						res_err_q  <= 1'b0;
					end else begin
						res_pose_q <= '0;
						res_err_q  <= (fill_count_q == '0);
					end
				end
			end
			phntl_pkg::ST_WALK: begin
				if (hit) begin
					res_pose_q <= rd_pose;
					old_time_q <= rd_time;
					old_pose_q <= rd_pose;
				end else begin
					// When every entry is later, the oldest one read last is the answer.
					res_pose_q  <= rd_pose;
					prev_time_q <= rd_time;
					prev_pose_q <= rd_pose;
					rd_ptr_q    <= rd_ptr_dec;
					ev_k_q      <= ev_k_q + AW'(1);
				end
			end
			phntl_pkg::ST_GAP: begin
				gap_old_q <= time_q - old_time_q;
				gap_new_q <= prev_time_q - time_q;
			end
			phntl_pkg::ST_SEL: begin
				res_pose_q <= (gap_old_q <= gap_new_q) ? old_pose_q : prev_pose_q;
			end
			phntl_pkg::ST_DONE: begin
				if (out_free) begin
					pose_number_q <= res_pose_q;
					empty_error_q <= res_err_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign pose_number = pose_number_q;
	assign empty_error = empty_error_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count_q <= FW'(HISTORY_DEPTH))
		else $error("fill count beyond history depth");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == phntl_pkg::ST_WALK |-> FW'(ev_k_q) < fill_count_q)
		else $error("walk left the filled part of the history");

	a_empty_query: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && action == phntl_pkg::ACT_QUERY && fill_count_q == '0
		|=> state_q == phntl_pkg::ST_DONE && res_err_q)
		else $error("query on empty history not flagged");

	a_err_zero_pose: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && empty_error_q |-> pose_number_q == '0)
		else $error("empty error with non-zero pose number");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == phntl_pkg::ST_DONE)
		else $error("result offered without a finished beat");
`endif

endmodule

`default_nettype wire
